// ===== rtl/trc_pkg.sv =====
package trc_pkg;

	localparam int ADDR_W = 5;
	localparam int NUM_W  = 31;   // |uv span| * edge movement
	localparam int DEN_W  = 15;   // rectangle width or height
	localparam int QUO_W  = 17;   // quotient never exceeds the uv span
	localparam int PROD_W = 43;   // 17-bit position times 26-bit scale

	localparam logic [2:0] REG_CLIP_LEFT   = 3'd0;
	localparam logic [2:0] REG_CLIP_TOP    = 3'd1;
	localparam logic [2:0] REG_CLIP_WIDTH  = 3'd2;
	localparam logic [2:0] REG_CLIP_HEIGHT = 3'd3;
	localparam logic [2:0] REG_X_SCALE     = 3'd4;
	localparam logic [2:0] REG_Y_SCALE     = 3'd5;

	typedef struct packed {
		logic signed [15:0] clip_left;
		logic signed [15:0] clip_top;
		logic [14:0]        clip_width;
		logic [14:0]        clip_height;
		logic signed [25:0] x_scale;
		logic signed [25:0] y_scale;
	} cfg_t;

	typedef struct packed {
		logic [15:0] x0, x1, y0, y1;
		logic [15:0] u0, u1, v0, v1;
		logic [31:0] c_tl, c_tr, c_bl, c_br;
	} quad_t;

	function automatic logic signed [16:0] clamp17(input logic signed [16:0] v,
		input logic signed [16:0] lo, input logic signed [16:0] hi);
		logic signed [16:0] r;
		r = v;
		if (r < lo) r = lo;
		if (r > hi) r = hi;
		return r;
	endfunction

	// device position: round Q.24 to Q2.14, ties away from zero, saturate
	function automatic logic [15:0] pos_fix(input logic signed [PROD_W-1:0] prod,
		input logic add_one);
		logic signed [PROD_W:0] v;
		logic [PROD_W:0]        mag;
		logic [PROD_W:0]        sum;
		logic [33:0]            q;
		logic [15:0]            r;
		v = {prod[PROD_W-1], prod};
		if (add_one) v = v + (PROD_W+1)'(1 << 24);
		else v = v - (PROD_W+1)'(1 << 24);
		mag = v[PROD_W] ? (~v + 1'b1) : v;
		sum = mag + (PROD_W+1)'(512);
		q = sum[PROD_W:10];
		if (!v[PROD_W]) r = (q > 34'd32767) ? 16'h7fff : q[15:0];
		else r = (q > 34'd32768) ? 16'h8000 : (~q[15:0] + 16'd1);
		return r;
	endfunction

	// base + signed, rounded (span*move/size), clamped to 0..65535
	function automatic logic [15:0] uv_fix(input logic [15:0] base,
		input logic [QUO_W-1:0] quo, input logic [DEN_W-1:0] rem,
		input logic [DEN_W-1:0] den, input logic neg);
		logic              up;
		logic [QUO_W:0]    qr;
		logic [18:0]       sh;
		logic signed [18:0] s;
		logic [15:0]       r;
		up = ({rem, 1'b0} >= {1'b0, den});
		qr = {1'b0, quo} + {{QUO_W{1'b0}}, up};
		if (den == '0) qr = '0;
		sh = {{(18-QUO_W){1'b0}}, qr};
		if (neg) sh = 19'd0 - sh;
		s = $signed({3'b000, base}) + $signed(sh);
		if (s < 0) r = 16'd0;
		else if (s > 19'sd65535) r = 16'hffff;
		else r = s[15:0];
		return r;
	endfunction

endpackage

// ===== rtl/trc_regs.sv =====
module trc_regs import trc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	output cfg_t              cfg
);
	cfg_t cfg_q;
	logic [2:0] idx;

	assign idx = paddr[ADDR_W-1:2];
	assign pready = 1'b1;
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (psel && penable && pwrite) begin
			case (idx)
				REG_CLIP_LEFT:   cfg_q.clip_left   <= pwdata[15:0];
				REG_CLIP_TOP:    cfg_q.clip_top    <= pwdata[15:0];
				REG_CLIP_WIDTH:  cfg_q.clip_width  <= pwdata[14:0];
				REG_CLIP_HEIGHT: cfg_q.clip_height <= pwdata[14:0];
				REG_X_SCALE:     cfg_q.x_scale     <= pwdata[25:0];
				REG_Y_SCALE:     cfg_q.y_scale     <= pwdata[25:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_CLIP_LEFT:   prdata = 32'(cfg_q.clip_left);
			REG_CLIP_TOP:    prdata = 32'(cfg_q.clip_top);
			REG_CLIP_WIDTH:  prdata = {17'd0, cfg_q.clip_width};
			REG_CLIP_HEIGHT: prdata = {17'd0, cfg_q.clip_height};
			REG_X_SCALE:     prdata = 32'(cfg_q.x_scale);
			REG_Y_SCALE:     prdata = 32'(cfg_q.y_scale);
			default:         prdata = 32'd0;
		endcase
	end
endmodule

// ===== rtl/trc_div.sv =====
// restoring divider, one quotient bit per stage; quotient known to fit QUO_W bits
module trc_div import trc_pkg::*; (
	input  logic             clk,
	input  logic             en,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic [QUO_W-1:0] quo,
	output logic [DEN_W-1:0] rem,
	output logic [DEN_W-1:0] den_out
);
	logic [NUM_W-1:0] num_s [QUO_W];
	logic [DEN_W-1:0] den_s [QUO_W];
	logic [DEN_W-1:0] rem_s [QUO_W];
	logic [QUO_W-1:0] quo_s [QUO_W];

	for (genvar i = 0; i < QUO_W; i++) begin : g_st
		logic [NUM_W-1:0] n_in;
		logic [DEN_W-1:0] d_in;
		logic [DEN_W-1:0] r_in;
		logic [QUO_W-1:0] q_in;
		logic [DEN_W:0]   trial;
		logic             ge;

		if (i == 0) begin : g_first
			assign n_in = num;
			assign d_in = den;
			assign r_in = {{(DEN_W-(NUM_W-QUO_W)){1'b0}}, num[NUM_W-1:QUO_W]};
			assign q_in = '0;
		end else begin : g_next
			assign n_in = num_s[i-1];
			assign d_in = den_s[i-1];
			assign r_in = rem_s[i-1];
			assign q_in = quo_s[i-1];
		end

		assign trial = {r_in, n_in[QUO_W-1-i]};
		assign ge = (trial >= {1'b0, d_in});

		always_ff @(posedge clk) begin
			if (en) begin
				num_s[i] <= n_in;
				den_s[i] <= d_in;
				rem_s[i] <= ge ? DEN_W'(trial - {1'b0, d_in}) : trial[DEN_W-1:0];
				quo_s[i] <= {q_in[QUO_W-2:0], ge};
			end
		end
	end

	assign quo = quo_s[QUO_W-1];
	assign rem = rem_s[QUO_W-1];
	assign den_out = den_s[QUO_W-1];
endmodule

// ===== rtl/trc_ser.sv =====
module trc_ser import trc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        load,
	input  quad_t       quad,
	output logic        can_load,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [15:0] pos_x,
	output logic [15:0] pos_y,
	output logic [15:0] tex_u,
	output logic [15:0] tex_v,
	output logic [31:0] vertex_colour,
	output logic        last_vertex
);
	quad_t      quad_q;
	logic [1:0] cnt_q;
	logic       vld_q;

	assign can_load = !vld_q || (out_ready && cnt_q == 2'd3);
	assign out_valid = vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
			cnt_q <= 2'd0;
		end else if (load) begin
			vld_q <= 1'b1;
			cnt_q <= 2'd0;
		end else if (vld_q && out_ready) begin
			if (cnt_q == 2'd3) vld_q <= 1'b0;
			cnt_q <= cnt_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) quad_q <= quad;
	end

	// order tl, tr, bl, br: bit 0 picks right, bit 1 picks bottom
	always_comb begin
		pos_x = cnt_q[0] ? quad_q.x1 : quad_q.x0;
		tex_u = cnt_q[0] ? quad_q.u1 : quad_q.u0;
		pos_y = cnt_q[1] ? quad_q.y1 : quad_q.y0;
		tex_v = cnt_q[1] ? quad_q.v1 : quad_q.v0;
		case (cnt_q)
			2'd0:    vertex_colour = quad_q.c_tl;
			2'd1:    vertex_colour = quad_q.c_tr;
			2'd2:    vertex_colour = quad_q.c_bl;
			default: vertex_colour = quad_q.c_br;
		endcase
		last_vertex = (cnt_q == 2'd3);
	end
endmodule

// ===== rtl/textured_rect_clip_to_quad_core.sv =====
// Scissor clip of textured rectangles into four-vertex quads. One request is a
// rectangle with uv range and corner colours; it yields four vertices (tl, tr,
// bl, br) or nothing when no corner touches the clip rectangle. A rectangle is
// accepted every cycle while the pipe flows, but the vertex port gives one
// vertex per cycle while out_ready is high, and each rectangle yields four, so
// the output serializer limits throughput. The first vertex is presented after
// clamp, multiply, a 17-stage divider for the uv shift (one quotient bit per
// stage), then the vertex register. Configure registers only while the block is
// idle.
module textured_rect_clip_to_quad_core import trc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [15:0]       rect_left,
	input  logic [15:0]       rect_top,
	input  logic [14:0]       rect_width,
	input  logic [14:0]       rect_height,
	input  logic [15:0]       u_left,
	input  logic [15:0]       v_top,
	input  logic [15:0]       u_right,
	input  logic [15:0]       v_bottom,
	input  logic [31:0]       colour_top_left,
	input  logic [31:0]       colour_top_right,
	input  logic [31:0]       colour_bottom_left,
	input  logic [31:0]       colour_bottom_right,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [15:0]       pos_x,
	output logic [15:0]       pos_y,
	output logic [15:0]       tex_u,
	output logic [15:0]       tex_v,
	output logic [31:0]       vertex_colour,
	output logic              last_vertex
);
	typedef struct packed {
		logic [15:0] px0, px1, py0, py1;
		logic [15:0] u1, u2, v1, v2;
		logic        nul, nur, nvt, nvb;
		logic [31:0] c0, c1, c2, c3;
	} pay_t;

	cfg_t  cfg;
	logic  pipe_en, can_load, fin_v, keep;
	quad_t quad;
	logic  vd_s  [QUO_W];

	trc_regs u_regs (
		.clk, .arst_n, .psel, .penable, .pwrite, .paddr, .pwdata,
		.prdata, .pready, .cfg
	);

	assign fin_v = vd_s[QUO_W-1];
	assign pipe_en = can_load || !fin_v;
	assign in_ready = pipe_en;

	// stage 1: inside test and edge clamp
	logic signed [16:0] left, top, right, bottom, cl, ct, cr, cb;
	logic signed [16:0] nl, nr, nt, nb, su, sv;
	logic               in_tl, in_tr, in_bl, in_br;

	always_comb begin
		left   = 17'(signed'(rect_left));
		top    = 17'(signed'(rect_top));
		right  = left + $signed({2'b00, rect_width});
		bottom = top + $signed({2'b00, rect_height});
		cl     = 17'(cfg.clip_left);
		ct     = 17'(cfg.clip_top);
		cr     = cl + $signed({2'b00, cfg.clip_width});
		cb     = ct + $signed({2'b00, cfg.clip_height});
		in_tl  = left >= cl && left <= cr && top >= ct && top <= cb;
		in_tr  = right >= cl && right <= cr && top >= ct && top <= cb;
		in_bl  = left >= cl && left <= cr && bottom >= ct && bottom <= cb;
		in_br  = right >= cl && right <= cr && bottom >= ct && bottom <= cb;
		keep   = in_tl || in_tr || in_bl || in_br;
		nl     = clamp17(left, cl, cr);
		nr     = clamp17(right, cl, cr);
		nt     = clamp17(top, ct, cb);
		nb     = clamp17(bottom, ct, cb);
		su     = $signed({1'b0, u_right}) - $signed({1'b0, u_left});
		sv     = $signed({1'b0, v_bottom}) - $signed({1'b0, v_top});
	end

	logic               v_s1;
	logic signed [16:0] nl_s1, nr_s1, nt_s1, nb_s1;
	logic [14:0]        ml_s1, mr_s1, mt_s1, mb_s1, w_s1, h_s1;
	logic [15:0]        sum_s1, svm_s1, u1_s1, u2_s1, v1_s1, v2_s1;
	logic               sun_s1, svn_s1;
	logic [31:0]        c0_s1, c1_s1, c2_s1, c3_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (pipe_en) v_s1 <= in_valid && keep;
	end

	// with a corner inside, every edge moves inward by at most the size
	always_ff @(posedge clk) begin
		if (pipe_en) begin
			nl_s1  <= nl;
			nr_s1  <= nr;
			nt_s1  <= nt;
			nb_s1  <= nb;
			ml_s1  <= 15'(nl - left);
			mr_s1  <= 15'(right - nr);
			mt_s1  <= 15'(nt - top);
			mb_s1  <= 15'(bottom - nb);
			w_s1   <= rect_width;
			h_s1   <= rect_height;
			sun_s1 <= su[16];
			svn_s1 <= sv[16];
			sum_s1 <= su[16] ? 16'(-su) : su[15:0];
			svm_s1 <= sv[16] ? 16'(-sv) : sv[15:0];
			u1_s1  <= u_left;
			u2_s1  <= u_right;
			v1_s1  <= v_top;
			v2_s1  <= v_bottom;
			c0_s1  <= colour_top_left;
			c1_s1  <= colour_top_right;
			c2_s1  <= colour_bottom_left;
			c3_s1  <= colour_bottom_right;
		end
	end

	// stage 2: products
	logic                     v_s2;
	logic [NUM_W-1:0]         pul_s2, pur_s2, pvt_s2, pvb_s2;
	logic signed [PROD_W-1:0] xl_s2, xr_s2, yt_s2, yb_s2;
	logic [14:0]              w_s2, h_s2;
	logic                     sun_s2, svn_s2;
	logic [15:0]              u1_s2, u2_s2, v1_s2, v2_s2;
	logic [31:0]              c0_s2, c1_s2, c2_s2, c3_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else if (pipe_en) v_s2 <= v_s1;
	end

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			pul_s2 <= sum_s1 * ml_s1;
			pur_s2 <= sum_s1 * mr_s1;
			pvt_s2 <= svm_s1 * mt_s1;
			pvb_s2 <= svm_s1 * mb_s1;
			xl_s2  <= nl_s1 * cfg.x_scale;
			xr_s2  <= nr_s1 * cfg.x_scale;
			yt_s2  <= nt_s1 * cfg.y_scale;
			yb_s2  <= nb_s1 * cfg.y_scale;
			w_s2   <= w_s1;
			h_s2   <= h_s1;
			sun_s2 <= sun_s1;
			svn_s2 <= svn_s1;
			u1_s2  <= u1_s1;
			u2_s2  <= u2_s1;
			v1_s2  <= v1_s1;
			v2_s2  <= v2_s1;
			c0_s2  <= c0_s1;
			c1_s2  <= c1_s1;
			c2_s2  <= c2_s1;
			c3_s2  <= c3_s1;
		end
	end

	// divider stages: payload rides alongside, positions finished on entry
	pay_t pay_s [QUO_W];
	pay_t pay_in;

	always_comb begin
		pay_in.px0 = pos_fix(xl_s2, 1'b0);
		pay_in.px1 = pos_fix(xr_s2, 1'b0);
		pay_in.py0 = pos_fix(yt_s2, 1'b1);
		pay_in.py1 = pos_fix(yb_s2, 1'b1);
		pay_in.u1  = u1_s2;
		pay_in.u2  = u2_s2;
		pay_in.v1  = v1_s2;
		pay_in.v2  = v2_s2;
		pay_in.nul = sun_s2;
		pay_in.nur = !sun_s2;
		pay_in.nvt = svn_s2;
		pay_in.nvb = !svn_s2;
		pay_in.c0  = c0_s2;
		pay_in.c1  = c1_s2;
		pay_in.c2  = c2_s2;
		pay_in.c3  = c3_s2;
	end

	for (genvar i = 0; i < QUO_W; i++) begin : g_pipe
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) vd_s[i] <= 1'b0;
			else if (pipe_en) vd_s[i] <= (i == 0) ? v_s2 : vd_s[(i == 0) ? 0 : i-1];
		end
		always_ff @(posedge clk) begin
			if (pipe_en) pay_s[i] <= (i == 0) ? pay_in : pay_s[(i == 0) ? 0 : i-1];
		end
	end

	logic [QUO_W-1:0] q_ul, q_ur, q_vt, q_vb;
	logic [DEN_W-1:0] r_ul, r_ur, r_vt, r_vb, d_ul, d_ur, d_vt, d_vb;

	trc_div u_div_ul (.clk, .en(pipe_en), .num(pul_s2), .den(w_s2),
		.quo(q_ul), .rem(r_ul), .den_out(d_ul));
	trc_div u_div_ur (.clk, .en(pipe_en), .num(pur_s2), .den(w_s2),
		.quo(q_ur), .rem(r_ur), .den_out(d_ur));
	trc_div u_div_vt (.clk, .en(pipe_en), .num(pvt_s2), .den(h_s2),
		.quo(q_vt), .rem(r_vt), .den_out(d_vt));
	trc_div u_div_vb (.clk, .en(pipe_en), .num(pvb_s2), .den(h_s2),
		.quo(q_vb), .rem(r_vb), .den_out(d_vb));

	pay_t fin;
	assign fin = pay_s[QUO_W-1];

	always_comb begin
		quad.x0   = fin.px0;
		quad.x1   = fin.px1;
		quad.y0   = fin.py0;
		quad.y1   = fin.py1;
		quad.u0   = uv_fix(fin.u1, q_ul, r_ul, d_ul, fin.nul);
		quad.u1   = uv_fix(fin.u2, q_ur, r_ur, d_ur, fin.nur);
		quad.v0   = uv_fix(fin.v1, q_vt, r_vt, d_vt, fin.nvt);
		quad.v1   = uv_fix(fin.v2, q_vb, r_vb, d_vb, fin.nvb);
		quad.c_tl = fin.c0;
		quad.c_tr = fin.c1;
		quad.c_bl = fin.c2;
		quad.c_br = fin.c3;
	end

	trc_ser u_ser (
		.clk, .arst_n, .load(fin_v && can_load), .quad, .can_load,
		.out_valid, .out_ready, .pos_x, .pos_y, .tex_u, .tex_v,
		.vertex_colour, .last_vertex
	);

`ifndef NO_ASSERTIONS
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!pipe_en |=> (v_s1 == $past(v_s1) && v_s2 == $past(v_s2)))
		else $error("pipeline moved while stalled");
	a_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && !keep) |=> !v_s1)
		else $error("rejected rectangle entered pipeline");
	a_load: assert property (@(posedge clk) disable iff (!arst_n)
		(fin_v && pipe_en) |=> (out_valid && !last_vertex))
		else $error("finished quad not presented");
`endif
endmodule
